// File: rtl/bba_pkg.sv
// Shared types and constants of the block bitmap allocator.
`timescale 1ns / 1ps

package bba_pkg;

   localparam int MAX_BLOCKS_DEFAULT  = 1024;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int BLOCKS_RESET        = 1024;
   localparam int COUNT_W             = 11;
   localparam int WORD_W              = 32;
   localparam int WORD_SH             = 5;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_CHECK = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } bba_op_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_RESIZE,
      BK_TRIM_RD,
      BK_TRIM_WR,
      BK_IDLE,
      BK_SCAN,
      BK_BYTE_RD,
      BK_BYTE_USE,
      BK_REPLY
   } bba_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  byte_index;
      logic [7:0]  byte_value;
      logic [10:0] needed_count;
   } bba_req_type;

   typedef struct packed {
      logic [9:0] block_index;
      logic       found;
      logic       enough;
      logic [7:0] read_byte;
   } bba_rsp_type;

   // Classified command as handed from the front end to the back end.
   typedef struct packed {
      bba_op_type  op;
      logic [4:0]  word;
      logic [1:0]  lane;
      logic [7:0]  value;
      logic [7:0]  lane_mask;
      logic [10:0] need;
   } bba_cmd_type;

endpackage

// File: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bba_fifo.sv
// Small register queue used between the allocator stages.
`timescale 1ns / 1ps

module bba_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/bba_front.sv
// Front end: accepts request transactions, classifies them and queues them.
`timescale 1ns / 1ps

module bba_front #(
   parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int QUEUE_DEPTH = bba_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
   localparam int CMP_W = (CNT_W > bba_pkg::COUNT_W) ? CNT_W : bba_pkg::COUNT_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bba_pkg::bba_req_type req,
   output logic                 full,
   input  logic [CNT_W-1:0]     cover_count,
   output bba_pkg::bba_cmd_type head,
   output logic                 empty,
   input  logic                 pop
);

   bba_pkg::bba_cmd_type cls;
   logic [CMP_W-1:0]     byte_wide;
   logic [CMP_W-1:0]     full_bytes;
   logic [2:0]           tail_bits;

   // Work out which bits of the addressed byte lie below the covered count.
   assign byte_wide  = CMP_W'(req.byte_index);
   assign full_bytes = CMP_W'(cover_count) >> 3;
   assign tail_bits  = cover_count[2:0];

   always_comb begin
      cls.op    = bba_pkg::bba_op_type'(req.command);
      cls.word  = req.byte_index[6:2];
      cls.lane  = req.byte_index[1:0];
      cls.value = req.byte_value;
      cls.need  = req.needed_count;
      if (byte_wide < full_bytes) begin
         cls.lane_mask = 8'hFF;
      end else if (byte_wide == full_bytes) begin
         cls.lane_mask = (8'd1 << tail_bits) - 8'd1;
      end else begin
         cls.lane_mask = 8'd0;
      end
   end

   bba_fifo #(
      .WIDTH ($bits(bba_pkg::bba_cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cls),
      .full  (full),
      .pop   (pop),
      .rdata (head),
      .empty (empty)
   );

endmodule

// File: rtl/bba_back.sv
// Back end: owns the bitmap memory, runs scans, byte accesses and clearing passes.
`timescale 1ns / 1ps

module bba_back #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT,
   localparam int WORD_W = bba_pkg::WORD_W,
   localparam int WORD_SH = bba_pkg::WORD_SH,
   localparam int WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W,
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1,
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1),
   localparam int CMP_W  = (CNT_W > bba_pkg::COUNT_W) ? CNT_W : bba_pkg::COUNT_W,
   localparam int N_RST  = (bba_pkg::BLOCKS_RESET > MAX_BLOCKS) ?
                           MAX_BLOCKS : bba_pkg::BLOCKS_RESET
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bba_pkg::COUNT_W-1:0]  csr_wdata,
   input  bba_pkg::bba_cmd_type         cmd_head,
   input  logic                         cmd_empty,
   output logic                         cmd_pop,
   input  logic                         rsp_full,
   output logic                         rsp_push,
   output bba_pkg::bba_rsp_type         rsp_data,
   output logic                         clearing,
   output logic [CNT_W-1:0]             cover_count
);

   bba_pkg::bba_state_type state_ff, state_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   bba_pkg::bba_cmd_type   cur_ff, cur_in;
   logic [ADDR_W:0]        addr_ff, addr_in;
   logic                   rv_ff, rv_in;
   logic [ADDR_W-1:0]      rw_ff, rw_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   bba_pkg::bba_rsp_type   res_ff, res_in;
   logic                   pw_ff, pw_in;
   logic [ADDR_W-1:0]      wa_ff, wa_in;
   logic [WORD_W-1:0]      wd_ff, wd_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [WORD_W-1:0]      ram_wdata;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [WORD_W-1:0]      ram_rdata;

   logic [CMP_W-1:0]       n_wide;
   logic [CMP_W-1:0]       nw_wide;
   logic [WORD_SH-1:0]     rem;
   logic [CMP_W-1:0]       last_wide;
   logic [ADDR_W:0]        last_words;
   logic [ADDR_W-1:0]      trim_word;
   logic                   nw_in_range;
   logic [CMP_W-1:0]       csr_wide;
   logic [CNT_W-1:0]       n_new;
   logic                   start;

   logic [WORD_W-1:0]      scan_mask;
   logic [WORD_W-1:0]      free_bits;
   logic [WORD_W-1:0]      low_bit;
   logic [WORD_SH-1:0]     hit_pos;
   logic [5:0]             pop_cnt;
   logic                   scan_last;
   logic                   scan_hit;
   logic [ADDR_W+WORD_SH+9:0] idx_wide;

   logic [ADDR_W-1:0]      byte_word;
   logic [ADDR_W+4:0]      byte_word_wide;
   logic [WORD_SH-1:0]     lane_sh;
   logic [7:0]             byte_now;
   logic [WORD_W-1:0]      lane_m32;
   logic [WORD_W-1:0]      val_m32;
   logic                   enough_cmp;

   function automatic logic [WORD_W-1:0] cover_mask(input logic [ADDR_W-1:0] w,
                                                    input logic [CMP_W-1:0] nw,
                                                    input logic [WORD_SH-1:0] r);
      logic [CMP_W-1:0] wx;
      wx = CMP_W'(w);
      if (wx < nw) begin
         return '1;
      end else if (wx == nw) begin
         return (WORD_W'(1) << r) - WORD_W'(1);
      end
      return '0;
   endfunction

   function automatic logic [5:0] popcount32(input logic [WORD_W-1:0] v);
      logic [1:0] s1 [16];
      logic [2:0] s2 [8];
      logic [3:0] s3 [4];
      logic [4:0] s4 [2];
      for (int i = 0; i < 16; i++) begin
         s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      end
      return {1'b0, s4[0]} + {1'b0, s4[1]};
   endfunction

   function automatic logic [WORD_SH-1:0] onehot_index(input logic [WORD_W-1:0] oh);
      logic [WORD_SH-1:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (oh[i]) begin
            pos = pos | WORD_SH'(i);
         end
      end
      return pos;
   endfunction

   // Covered-range bookkeeping.
   assign n_wide      = CMP_W'(n_ff);
   assign nw_wide     = n_wide >> WORD_SH;
   assign rem         = n_wide[WORD_SH-1:0];
   assign last_wide   = nw_wide + CMP_W'(rem != '0);
   assign last_words  = last_wide[ADDR_W:0];
   assign trim_word   = nw_wide[ADDR_W-1:0];
   assign nw_in_range = nw_wide < CMP_W'(WORDS);
   assign csr_wide    = CMP_W'(csr_wdata);
   assign n_new       = (csr_wide > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(csr_wide);

   assign csr_ready   = (state_ff == bba_pkg::BK_IDLE);
   assign start       = (state_ff == bba_pkg::BK_IDLE) && !csr_valid && !cmd_empty && !rsp_full;
   assign cmd_pop     = start;
   assign cover_count = n_ff;
   assign clearing    = (state_ff == bba_pkg::BK_CLEAR) || (state_ff == bba_pkg::BK_RESIZE) ||
                        (state_ff == bba_pkg::BK_TRIM_RD) || (state_ff == bba_pkg::BK_TRIM_WR);

   // Scan datapath on the word returned by the memory.
   assign scan_mask = cover_mask(rw_ff, nw_wide, rem);
   assign free_bits = ~ram_rdata & scan_mask;
   assign low_bit   = free_bits & (~free_bits + WORD_W'(1));
   assign hit_pos   = onehot_index(low_bit);
   assign pop_cnt   = popcount32(free_bits);
   assign scan_last = rv_ff && ({1'b0, rw_ff} == last_words - 1'b1);
   assign scan_hit  = rv_ff && (cur_ff.op == bba_pkg::OP_ALLOC) && (free_bits != '0);
   assign idx_wide  = {10'b0, rw_ff, hit_pos};

   // Byte access datapath.
   assign byte_word_wide = {ADDR_W'(0), cur_ff.word};
   assign byte_word      = byte_word_wide[ADDR_W-1:0];
   assign lane_sh        = {cur_ff.lane, 3'b000};
   assign byte_now       = 8'(ram_rdata >> lane_sh);
   assign lane_m32       = WORD_W'(cur_ff.lane_mask) << lane_sh;
   assign val_m32        = WORD_W'(cur_ff.value) << lane_sh;
   assign enough_cmp     = CMP_W'(cnt_ff) >= CMP_W'(cur_ff.need);

   always_comb begin
      rsp_data        = res_ff;
      rsp_data.enough = (cur_ff.op == bba_pkg::OP_CHECK) && enough_cmp;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::BK_CLEAR: begin
            if (clr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = bba_pkg::BK_IDLE;
            end
         end
         bba_pkg::BK_RESIZE: begin
            if (!nw_in_range) begin
               state_in = bba_pkg::BK_IDLE;
            end else if (rem != '0) begin
               state_in = bba_pkg::BK_TRIM_RD;
            end else begin
               state_in = bba_pkg::BK_CLEAR;
            end
         end
         bba_pkg::BK_TRIM_RD: state_in = bba_pkg::BK_TRIM_WR;
         bba_pkg::BK_TRIM_WR: begin
            state_in = (trim_word == ADDR_W'(WORDS - 1)) ? bba_pkg::BK_IDLE : bba_pkg::BK_CLEAR;
         end
         bba_pkg::BK_IDLE: begin
            if (csr_valid) begin
               state_in = bba_pkg::BK_RESIZE;
            end else if (start) begin
               case (cmd_head.op)
                  bba_pkg::OP_ALLOC, bba_pkg::OP_CHECK: begin
                     state_in = (last_words == '0) ? bba_pkg::BK_REPLY : bba_pkg::BK_SCAN;
                  end
                  default: begin
                     state_in = (cmd_head.lane_mask == '0) ? bba_pkg::BK_REPLY :
                                bba_pkg::BK_BYTE_RD;
                  end
               endcase
            end
         end
         bba_pkg::BK_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = bba_pkg::BK_REPLY;
            end
         end
         bba_pkg::BK_BYTE_RD:  state_in = bba_pkg::BK_BYTE_USE;
         bba_pkg::BK_BYTE_USE: state_in = bba_pkg::BK_REPLY;
         bba_pkg::BK_REPLY:    state_in = bba_pkg::BK_IDLE;
         default:              state_in = bba_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      n_in      = n_ff;
      cur_in    = cur_ff;
      addr_in   = addr_ff;
      rv_in     = 1'b0;
      rw_in     = rw_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      pw_in     = pw_ff;
      wa_in     = wa_ff;
      wd_in     = wd_ff;
      clr_in    = clr_ff;
      ram_we    = 1'b0;
      ram_waddr = wa_ff;
      ram_wdata = wd_ff;
      ram_raddr = addr_ff[ADDR_W-1:0];
      rsp_push  = 1'b0;
      case (state_ff)
         bba_pkg::BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         bba_pkg::BK_RESIZE: begin
            clr_in = trim_word;
         end
         bba_pkg::BK_TRIM_RD: begin
            ram_raddr = trim_word;
         end
         bba_pkg::BK_TRIM_WR: begin
            // Drop the bits of the partial word that fall outside the new count.
            ram_we    = 1'b1;
            ram_waddr = trim_word;
            ram_wdata = ram_rdata & cover_mask(trim_word, nw_wide, rem);
            clr_in    = trim_word + 1'b1;
         end
         bba_pkg::BK_IDLE: begin
            if (csr_valid) begin
               n_in = n_new;
            end else if (start) begin
               cur_in  = cmd_head;
               addr_in = '0;
               cnt_in  = '0;
               res_in  = '0;
               pw_in   = 1'b0;
            end
         end
         bba_pkg::BK_SCAN: begin
            // Keep one read in flight while the previous word is examined.
            if (addr_ff < last_words) begin
               ram_raddr = addr_ff[ADDR_W-1:0];
               addr_in   = addr_ff + 1'b1;
               rv_in     = 1'b1;
               rw_in     = addr_ff[ADDR_W-1:0];
            end
            if (scan_hit) begin
               pw_in              = 1'b1;
               wa_in              = rw_ff;
               wd_in              = ram_rdata | low_bit;
               res_in.found       = 1'b1;
               res_in.block_index = idx_wide[9:0];
            end else if (rv_ff && (cur_ff.op == bba_pkg::OP_CHECK)) begin
               cnt_in = cnt_ff + CNT_W'(pop_cnt);
            end
         end
         bba_pkg::BK_BYTE_RD: begin
            ram_raddr = byte_word;
         end
         bba_pkg::BK_BYTE_USE: begin
            if (cur_ff.op == bba_pkg::OP_READ) begin
               res_in.read_byte = byte_now & cur_ff.lane_mask;
            end else begin
               pw_in = 1'b1;
               wa_in = byte_word;
               wd_in = (ram_rdata & ~lane_m32) | (val_m32 & lane_m32);
            end
         end
         bba_pkg::BK_REPLY: begin
            ram_we   = pw_ff;
            rsp_push = 1'b1;
         end
         default: begin
            rsp_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::BK_CLEAR;
         n_ff     <= CNT_W'(N_RST);
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         pw_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         pw_ff    <= pw_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      addr_ff <= addr_in;
      rw_ff   <= rw_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      wa_ff   <= wa_in;
      wd_ff   <= wd_in;
   end

   bba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// File: rtl/block_bitmap_allocator_top.sv
// Allocate and check scan one 32-bit bitmap word per cycle from the map RAM,
// allocate stopping at its first hit. Map byte writes and reads fetch the word,
// then merge or extract the byte; past the covered count they skip the map.
// One command is executed at a time; the command and result queues hold two each.
// Synchronous reset starts a clearing pass over the whole map with full high;
// shrinking the block count runs the same pass from the new end of the map.
`timescale 1ns / 1ps

module block_bitmap_allocator_top #(
   parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int QUEUE_DEPTH = bba_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  bba_pkg::bba_req_type        req_item,
   output logic                        empty,
   input  logic                        pop,
   output bba_pkg::bba_rsp_type        rsp_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bba_pkg::COUNT_W-1:0] csr_wdata
);

   bba_pkg::bba_cmd_type cmd_head;
   logic                 cmd_empty;
   logic                 cmd_pop;
   logic                 cmd_full;
   logic                 rsp_full;
   logic                 rsp_push;
   bba_pkg::bba_rsp_type rsp_data;
   logic                 clearing;
   logic [CNT_W-1:0]     cover_count;

   // Hold off new transactions while the map is being cleared.
   assign full = cmd_full || clearing;

   bba_front #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push && !clearing),
      .req         (req_item),
      .full        (cmd_full),
      .cover_count (cover_count),
      .head        (cmd_head),
      .empty       (cmd_empty),
      .pop         (cmd_pop)
   );

   bba_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .cmd_head    (cmd_head),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data),
      .clearing    (clearing),
      .cover_count (cover_count)
   );

   bba_fifo #(
      .WIDTH ($bits(bba_pkg::bba_rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_data),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_item),
      .empty (empty)
   );

endmodule

// File: rtl/bba_checker.sv
// Port-level checks of the block bitmap allocator, bound to the top level.
`timescale 1ns / 1ps

module bba_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 full,
   input logic                 empty,
   input logic                 pop,
   input bba_pkg::bba_rsp_type rsp_item
);

   // Reset leaves no result and starts the clearing pass.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (empty && full))
      else $error("no clearing pass or stale result after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result dropped without pop");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_item))
      else $error("result changed while waiting");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.found) |-> (rsp_item.block_index == 10'd0))
      else $error("block index set without an allocation");

   a_alloc_only: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.found) |-> (!rsp_item.enough && (rsp_item.read_byte == 8'd0)))
      else $error("allocation result mixed with another command's fields");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (.*);

// File: dv/tb_block_bitmap_allocator_top.sv
// Self-checking testbench for the block bitmap allocator top level.
`timescale 1ns / 1ps

module tb_block_bitmap_allocator_top;

   localparam int MAP_SIZE     = bba_pkg::MAX_BLOCKS_DEFAULT;
   localparam int PHASE_ITEMS  = 60;
   localparam int RANDOM_PHASE = 22;
   localparam int MAX_PRINTS   = 20;

   typedef struct packed {
      logic                        is_cfg;
      logic                        calm;
      logic [bba_pkg::COUNT_W-1:0] cfg_value;
      bba_pkg::bba_req_type        req;
   } backlog_entry_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        push      = 1'b0;
   logic                        full;
   bba_pkg::bba_req_type        req_item  = '0;
   logic                        empty;
   logic                        pop       = 1'b0;
   bba_pkg::bba_rsp_type        rsp_item;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [bba_pkg::COUNT_W-1:0] csr_wdata = '0;

   // Allocator state as predicted
   bit [MAP_SIZE-1:0]  used_map;
   int unsigned        blocks_reg;

   backlog_entry_type     cmd_backlog[$];
   bba_pkg::bba_rsp_type  awaited_answers[$];

   logic req_took  = 1'b0;
   logic csr_took  = 1'b0;
   logic calm_mode = 1'b0;
   logic gen_calm  = 1'b0;
   int   gap_left   = 0;
   int   hold_left  = 150;
   int   stall_left = 0;

   int fail_count   = 0;
   int answers_seen = 0;
   int cfg_writes   = 0;
   int alloc_hits   = 0;
   int alloc_misses = 0;
   int checks_true  = 0;
   int checks_false = 0;
   int long_holds   = 1;

   block_bitmap_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned covered_span();
      return (blocks_reg > MAP_SIZE) ? MAP_SIZE : blocks_reg;
   endfunction

   // Resize: blocks at or above the new count drop back to free
   function automatic void resize_map(logic [bba_pkg::COUNT_W-1:0] value);
      int unsigned span;
      blocks_reg = 32'(value);
      span = covered_span();
      for (int i = 0; i < MAP_SIZE; i++)
         if (i >= span) used_map[i] = 1'b0;
   endfunction

   function automatic bba_pkg::bba_rsp_type bitmap_answer(bba_pkg::bba_req_type r);
      bba_pkg::bba_rsp_type a;
      int          span;
      int          blk;
      int          free_blocks;
      bit          done;
      a = '0;
      span = covered_span();
      free_blocks = 0;
      done = 1'b0;
      case (r.command)
         bba_pkg::OP_ALLOC: begin
            for (int i = 0; i < span; i++) begin
               if (!done && !used_map[i]) begin
                  used_map[i] = 1'b1;
                  a.block_index = i[9:0];
                  a.found = 1'b1;
                  done = 1'b1;
               end
            end
         end
         bba_pkg::OP_CHECK: begin
            for (int i = 0; i < span; i++)
               if (!used_map[i]) free_blocks++;
            a.enough = (free_blocks >= int'(r.needed_count));
         end
         bba_pkg::OP_WRITE: begin
            for (int b = 0; b < 8; b++) begin
               blk = 8 * int'(r.byte_index) + b;
               if (blk < span) used_map[blk] = r.byte_value[b];
            end
         end
         default: begin
            for (int b = 0; b < 8; b++) begin
               blk = 8 * int'(r.byte_index) + b;
               if (blk < span && used_map[blk]) a.read_byte[b] = 1'b1;
            end
         end
      endcase
      return a;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   function automatic int pick_gap(logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_req(input bba_pkg::bba_op_type op, input int idx, input int val,
                          input int need);
      backlog_entry_type e;
      e = '0;
      e.calm = gen_calm;
      e.req.command = op;
      e.req.byte_index = idx[6:0];
      e.req.byte_value = val[7:0];
      e.req.needed_count = need[10:0];
      cmd_backlog.push_back(e);
   endtask

   task automatic add_cfg(input int value);
      backlog_entry_type e;
      e = '0;
      e.is_cfg = 1'b1;
      e.calm = gen_calm;
      e.cfg_value = value[10:0];
      cmd_backlog.push_back(e);
   endtask

   task automatic add_random_items(input int span, input int count);
      int r;
      int idx;
      int val;
      int need;
      int top_byte;
      bba_pkg::bba_op_type op;
      top_byte = (span + 7) / 8 - 1;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 35) op = bba_pkg::OP_ALLOC;
         else if (r < 60) op = bba_pkg::OP_CHECK;
         else if (r < 80) op = bba_pkg::OP_WRITE;
         else op = bba_pkg::OP_READ;
         if (span > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, top_byte);
         else idx = $urandom_range(0, 127);
         r = $urandom_range(0, 99);
         if (r < 50) val = 8'hFF;
         else if (r < 65) val = 8'h00;
         else val = $urandom_range(0, 255);
         r = $urandom_range(0, 99);
         if (r < 50) need = $urandom_range(0, (span + 2 > 2047) ? 2047 : span + 2);
         else if (r < 70) need = $urandom_range(0, 8);
         else need = $urandom_range(0, 2047);
         add_req(op, idx, val, need);
      end
   endtask

   // Driver: request and register transactions, changed on the falling edge
   always @(negedge clock) begin
      logic want_push;
      logic want_csr;
      want_push = push;
      want_csr  = csr_valid;
      if (reset) begin
         want_push = 1'b0;
         want_csr  = 1'b0;
      end else begin
         if (push && req_took) want_push = 1'b0;
         if (csr_valid && csr_took) want_csr = 1'b0;
         if (!want_push && !want_csr) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (cmd_backlog.size() > 0) begin
               if (cmd_backlog[0].is_cfg) begin
                  // hold the register write until the block has drained
                  if (awaited_answers.size() == 0) begin
                     csr_wdata <= cmd_backlog[0].cfg_value;
                     calm_mode <= cmd_backlog[0].calm;
                     want_csr = 1'b1;
                     gap_left = pick_gap(cmd_backlog[0].calm);
                     void'(cmd_backlog.pop_front());
                  end
               end else begin
                  req_item  <= cmd_backlog[0].req;
                  calm_mode <= cmd_backlog[0].calm;
                  want_push = 1'b1;
                  gap_left = pick_gap(cmd_backlog[0].calm);
                  void'(cmd_backlog.pop_front());
               end
            end
         end
      end
      push      <= want_push;
      csr_valid <= want_csr;
   end

   // Receiver: random stalls, occasional long hold-off to back the block up
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 999);
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (calm_mode) begin
         pop <= 1'b1;
      end else if (r < 4) begin
         pop <= 1'b0;
         hold_left <= $urandom_range(100, 200);
         long_holds <= long_holds + 1;
      end else if (r < 40) begin
         pop <= 1'b0;
         stall_left <= $urandom_range(8, 40);
      end else if (r < 300) begin
         pop <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         pop <= 1'b1;
      end
   end

   // Monitor: sample on the rising edge, predict on acceptance, check on pop
   always @(posedge clock) begin
      bba_pkg::bba_rsp_type want;
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
      end else begin
         req_took <= push && !full;
         csr_took <= csr_valid && csr_ready;
         if (pop && !empty) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
               flag_mismatch("answer with nothing outstanding", int'(rsp_item), 0);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_item.block_index !== want.block_index)
                  flag_mismatch("block_index", int'(rsp_item.block_index),
                                int'(want.block_index));
               if (rsp_item.found !== want.found)
                  flag_mismatch("found", int'(rsp_item.found), int'(want.found));
               if (rsp_item.enough !== want.enough)
                  flag_mismatch("enough", int'(rsp_item.enough), int'(want.enough));
               if (rsp_item.read_byte !== want.read_byte)
                  flag_mismatch("read_byte", int'(rsp_item.read_byte), int'(want.read_byte));
            end
         end
         if (csr_valid && csr_ready) begin
            resize_map(csr_wdata);
            cfg_writes++;
         end
         if (push && !full) begin
            want = bitmap_answer(req_item);
            if (req_item.command == bba_pkg::OP_ALLOC) begin
               if (want.found) alloc_hits++;
               else alloc_misses++;
            end else if (req_item.command == bba_pkg::OP_CHECK) begin
               if (want.enough) checks_true++;
               else checks_false++;
            end
            awaited_answers.push_back(want);
         end
      end
   end

   initial begin
      #15_000_000;
      $display("block_bitmap_allocator_top test failed");
      $finish;
   end

   initial begin
      int counts[16];
      int span;
      counts = '{13, 2047, 0, 1, 64, 1023, 8, 1024, 100, 1025, 256, 7, 16, 512, 33, 1024};
      used_map = '0;
      blocks_reg = bba_pkg::BLOCKS_RESET;

      // Directed: reset count, map empty
      gen_calm = 1'b1;
      add_req(bba_pkg::OP_READ,  0,   0, 0);
      add_req(bba_pkg::OP_ALLOC, 0,   0, 0);
      add_req(bba_pkg::OP_ALLOC, 0,   0, 0);
      add_req(bba_pkg::OP_CHECK, 0,   0, 0);
      add_req(bba_pkg::OP_CHECK, 0,   0, 1024);
      add_req(bba_pkg::OP_CHECK, 0,   0, 1022);
      add_req(bba_pkg::OP_CHECK, 127, 255, 2047);
      add_req(bba_pkg::OP_WRITE, 127, 8'h80, 0);
      add_req(bba_pkg::OP_READ,  127, 0, 0);
      add_req(bba_pkg::OP_WRITE, 0,   8'hFF, 0);
      add_req(bba_pkg::OP_ALLOC, 0,   0, 0);
      add_req(bba_pkg::OP_READ,  1,   0, 0);
      add_req(bba_pkg::OP_WRITE, 0,   8'h00, 0);
      add_req(bba_pkg::OP_ALLOC, 0,   0, 0);
      // Shrink to one byte: fill it, then the map is full
      add_cfg(8);
      add_req(bba_pkg::OP_WRITE, 0,   8'h7F, 0);
      add_req(bba_pkg::OP_ALLOC, 0,   0, 0);
      add_req(bba_pkg::OP_ALLOC, 0,   0, 0);
      add_req(bba_pkg::OP_CHECK, 0,   0, 0);
      add_req(bba_pkg::OP_CHECK, 0,   0, 1);
      add_req(bba_pkg::OP_WRITE, 1,   8'hFF, 0);
      add_req(bba_pkg::OP_READ,  1,   0, 0);
      add_req(bba_pkg::OP_READ,  0,   0, 0);

      for (int p = 0; p < RANDOM_PHASE; p++) begin
         gen_calm = (p % 5 == 4);
         span = (p < 16) ? counts[p] : $urandom_range(0, 2047);
         add_cfg(span);
         add_random_items((span > MAP_SIZE) ? MAP_SIZE : span, PHASE_ITEMS);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(cmd_backlog.size() == 0 && !push && !csr_valid && awaited_answers.size() == 0))
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (awaited_answers.size() != 0)
         flag_mismatch("answers never delivered", awaited_answers.size(), 0);

      $display("Covered %0d answers over %0d count settings, %0d long receiver hold-offs",
               answers_seen, cfg_writes, long_holds);
      $display("Allocations %0d hit / %0d miss, checks %0d enough / %0d short",
               alloc_hits, alloc_misses, checks_true, checks_false);
      if (fail_count == 0) begin
         $display("block_bitmap_allocator_top test passed");
      end else begin
         $display("block_bitmap_allocator_top test failed");
      end
      $finish;
   end

endmodule
